>>> hw/rtl/tea_pkg.sv
`timescale 1ns / 1ps

package tea_pkg;

  // Fixed result and input field widths.
  localparam int NUMBER_W = 10;
  localparam int NEIGH_W  = 11;
  localparam int STATUS_W = 2;
  localparam int QIDX_W   = 10;
  localparam int OP_W     = 2;

  // Result fields packed, padded to whole bytes.
  localparam int OUT_FIELDS_W = NUMBER_W + 3 * NEIGH_W + STATUS_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [NEIGH_W-1:0] NO_NEIGHBOUR = {NEIGH_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QLOAD,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/tea_store.sv
`timescale 1ns / 1ps

module tea_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/tea_edge_match.sv
`timescale 1ns / 1ps

module tea_edge_match #(
  parameter int VB = 16,
  parameter int IW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic [3*VB-1:0] query_verts,
  input  logic          entry_valid,
  input  logic [3*VB-1:0] entry_verts,
  input  logic [IW-1:0] entry_index,
  output logic [2:0]    found,
  output logic [IW-1:0] hit_index [3]
);

  logic [VB-1:0] q_r [3];
  logic [VB-1:0] q_nxt [3];
  logic [VB-1:0] e [3];
  logic [2:0]    found_r;
  logic [2:0]    found_nxt;
  logic [IW-1:0] idx_r [3];
  logic [IW-1:0] idx_nxt [3];
  logic [2:0]    hit;

  // A stored triangle holds the reverse of query edge (u,v) when one of its
  // own directed edges runs from v back to u.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e[i] = entry_verts[i*VB +: VB];
    end
    for (int k = 0; k < 3; k++) begin
      hit[k] = 1'b0;
      for (int j = 0; j < 3; j++) begin
        if (e[j] == q_r[(k + 1) % 3] && e[(j + 1) % 3] == q_r[k]) begin
          hit[k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    found_nxt = found_r;
    for (int k = 0; k < 3; k++) begin
      q_nxt[k]   = q_r[k];
      idx_nxt[k] = idx_r[k];
    end
    if (load) begin
      found_nxt = '0;
      for (int k = 0; k < 3; k++) begin
        q_nxt[k] = query_verts[k*VB +: VB];
      end
    end else if (entry_valid) begin
      // Keep only the first, lowest-indexed holder of each edge.
      for (int k = 0; k < 3; k++) begin
        if (hit[k] && !found_r[k]) begin
          found_nxt[k] = 1'b1;
          idx_nxt[k]   = entry_index;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= '0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      q_r[k]   <= q_nxt[k];
      idx_r[k] <= idx_nxt[k];
    end
  end

  assign found = found_r;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hit_index[k] = idx_r[k];
    end
  end

endmodule

>>> hw/rtl/triangle_edge_adjacency_top.sv
`timescale 1ns / 1ps

// Triangle edge adjacency table. Each input transfer carries an opcode: add
// stores a triangle of three vertex indices under the next free index and
// returns that index, query returns for each directed edge a-b, b-c and c-a of a
// stored triangle the lowest-indexed stored triangle holding the reversed edge
// (-1 when there is none or when that holder is the queried triangle), and clear
// starts a new mesh. Every input transfer gives exactly one result transfer.
// Add, clear and unused opcodes go straight to the done state. A query of a
// stored index passes the load, scan, drain, finish and done states; its scan
// uses a single comparison unit that reads one stored triangle per cycle from
// the triangle memory and checks all three reversed edges against it; a query
// of an index that is not stored goes to the done state. No new item is taken
// while one is in progress, but an item may be accepted while the previous
// result still waits in the output register. No clearing pass is needed after
// reset: entries at or above the triangle count are never read.
module triangle_edge_adjacency_top #(
  parameter int MAX_TRIANGLES = 1024,
  parameter int VERTEX_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // Fields from bit 0 up: opcode, vert_a, vert_b, vert_c, query_index, zero pad.
  input  logic [((12 + 3 * VERTEX_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // Fields from bit 0 up: triangle_number, neighbour_ab, neighbour_bc,
  // neighbour_ca, status, zero pad.
  output logic [tea_pkg::OUT_DATA_W-1:0] out_tdata
);

  import tea_pkg::*;

  localparam int VB   = VERTEX_BITS;
  localparam int IW   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CW   = $clog2(MAX_TRIANGLES + 1);
  localparam int CMPW = (CW > QIDX_W) ? CW : QIDX_W;
  localparam int DW   = 3 * VB;

  // Input field decode.
  opcode_t           in_op;
  logic [DW-1:0]     in_verts;
  logic [QIDX_W-1:0] in_qi;

  assign in_op    = opcode_t'(in_tdata[OP_W-1:0]);
  assign in_verts = in_tdata[OP_W +: DW];
  assign in_qi    = in_tdata[OP_W + DW +: QIDX_W];

  state_t state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       scan_r, scan_nxt;
  logic [QIDX_W-1:0]   qi_r, qi_nxt;
  logic                tag_valid_r, tag_valid_nxt;
  logic [IW-1:0]       tag_idx_r, tag_idx_nxt;

  // Result waiting to be handed to the output register.
  logic [NUMBER_W-1:0] res_num_r, res_num_nxt;
  logic [NEIGH_W-1:0]  res_nb_r [3];
  logic [NEIGH_W-1:0]  res_nb_nxt [3];
  status_t             res_status_r, res_status_nxt;

  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic          in_fire;
  logic          mem_we;
  logic [IW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;
  logic          match_load;
  logic [2:0]    found;
  logic [IW-1:0] hit_index [3];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Adds write at the current count; that address is below the table size
  // whenever the table is not full.
  assign mem_we = in_fire && (in_op == OP_ADD) && (count_r != CW'(MAX_TRIANGLES));

  // While idle the read port looks at the requested query entry, so its data
  // is ready in the cycle after a query transfer.
  assign mem_raddr = (state_r == S_IDLE) ? IW'(in_qi) : scan_r;

  tea_store #(
    .DEPTH(MAX_TRIANGLES),
    .AW   (IW),
    .DW   (DW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(count_r[IW-1:0]),
    .wdata(in_verts),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign match_load = (state_r == S_QLOAD);

  tea_edge_match #(
    .VB(VB),
    .IW(IW)
  ) u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (match_load),
    .query_verts(mem_rdata),
    .entry_valid(tag_valid_r),
    .entry_verts(mem_rdata),
    .entry_index(tag_idx_r),
    .found      (found),
    .hit_index  (hit_index)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    qi_nxt         = qi_r;
    tag_valid_nxt  = 1'b0;
    tag_idx_nxt    = scan_r;
    res_num_nxt    = res_num_r;
    res_status_nxt = res_status_r;
    for (int k = 0; k < 3; k++) begin
      res_nb_nxt[k] = res_nb_r[k];
    end
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          qi_nxt         = in_qi;
          res_num_nxt    = '0;
          res_status_nxt = ST_OK;
          for (int k = 0; k < 3; k++) begin
            res_nb_nxt[k] = NO_NEIGHBOUR;
          end
          state_nxt = S_DONE;
          case (in_op)
            OP_ADD: begin
              if (count_r == CW'(MAX_TRIANGLES)) begin
                res_status_nxt = ST_FULL;
              end else begin
                res_num_nxt = NUMBER_W'(count_r);
                count_nxt   = count_r + 1'b1;
              end
            end
            OP_QUERY: begin
              res_num_nxt = in_qi;
              if (CMPW'(in_qi) < CMPW'(count_r)) begin
                state_nxt = S_QLOAD;
              end else begin
                res_status_nxt = ST_BAD_INDEX;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              // The unused opcode leaves the table alone.
            end
          endcase
        end
      end
      S_QLOAD: begin
        // The match unit latches the queried triangle now.
        scan_nxt  = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        tag_valid_nxt = 1'b1;
        tag_idx_nxt   = scan_r;
        if (CW'(scan_r) == count_r - 1'b1) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_DRAIN: begin
        // Last stored triangle is compared in this cycle.
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        for (int k = 0; k < 3; k++) begin
          if (!found[k] || CMPW'(hit_index[k]) == CMPW'(qi_r)) begin
            res_nb_nxt[k] = NO_NEIGHBOUR;
          end else begin
            res_nb_nxt[k] = NEIGH_W'(hit_index[k]);
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_DATA_W'({res_status_r, res_nb_r[2], res_nb_r[1],
                                        res_nb_r[0], res_num_r});
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      tag_valid_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      tag_valid_r  <= tag_valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    qi_r         <= qi_nxt;
    tag_idx_r    <= tag_idx_nxt;
    res_num_r    <= res_num_nxt;
    res_status_r <= res_status_nxt;
    out_tdata_r  <= out_tdata_nxt;
    for (int k = 0; k < 3; k++) begin
      res_nb_r[k] <= res_nb_nxt[k];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The scan never reads past the stored triangles.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CW'(scan_r) < count_r))
    else $error("scan address beyond triangle count");

  // Memory data is fed to the match unit only while a scan is running.
  a_tag_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tag_valid_r |-> (state_r == S_DRAIN || state_r == S_SCAN))
    else $error("match entry valid outside of a scan");

  // A full status is only produced when the table really is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_status_r == ST_FULL) |-> (count_r == CW'(MAX_TRIANGLES)))
    else $error("table full reported with free entries");

  // A query of a stored index goes straight to loading the queried entry.
  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == OP_QUERY && CMPW'(in_qi) < CMPW'(count_r)) |=>
      (state_r == S_QLOAD))
    else $error("valid query did not start a scan");

endmodule
